// ----- src/q2e_pkg.sv -----
package q2e_pkg;

   localparam int QBITS = 28;
   localparam int PROD_W = 32;
   localparam int SUM_W = 35;
   localparam int T_W = QBITS + 2;
   localparam int AT_W = QBITS + 1;
   localparam int V_W = 2 * QBITS + 1;
   localparam int SQRT_STAGES = QBITS + 1;
   localparam int ROOT_W = QBITS + 1;
   localparam int VEC_W = 36;
   localparam int ACC_W = 33;
   localparam int ANGLE_FRAC = 16;
   localparam int ANGLE_W = 16;
   localparam int ROLL_W = 16;
   localparam int PITCH_W = 15;
   localparam int YAW_W = 16;
   localparam int RSP_DATA_W = ((ROLL_W + PITCH_W + YAW_W + 7) / 8) * 8;
   localparam int ROLL_LIMIT = 18000;
   localparam int PITCH_LIMIT = 9000;
   localparam logic signed [ACC_W-1:0] QUARTER_TURN = 33'sd589824000;

   localparam logic signed [31:0] ATAN_TABLE [32] = '{
      32'sd294912000, 32'sd174096719, 32'sd91987925, 32'sd46694507, 32'sd23437865,
      32'sd11730358, 32'sd5866610, 32'sd2933484, 32'sd1466764, 32'sd733385,
      32'sd366693, 32'sd183346, 32'sd91673, 32'sd45837, 32'sd22918, 32'sd11459,
      32'sd5730, 32'sd2865, 32'sd1432, 32'sd716, 32'sd358, 32'sd179, 32'sd90,
      32'sd45, 32'sd22, 32'sd11, 32'sd6, 32'sd3, 32'sd1, 32'sd1, 32'sd0, 32'sd0
   };

endpackage

// ----- src/q2e_sqrt.sv -----
module q2e_sqrt (
   input  logic                          clock,
   input  logic                          en,
   input  logic [q2e_pkg::V_W-1:0]       v_in,
   output logic [q2e_pkg::ROOT_W-1:0]    root_out
);
   import q2e_pkg::*;

   logic [V_W-1:0]    rem_ff  [SQRT_STAGES];
   logic [ROOT_W-1:0] root_ff [SQRT_STAGES];

   for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_stage
      localparam int K = SQRT_STAGES - 1 - j;
      logic [V_W-1:0]    rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [V_W+1:0]    test;

      if (j == 0) begin : g_first
         assign rem_prev  = v_in;
         assign root_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[j-1];
         assign root_prev = root_ff[j-1];
      end

      assign test = ((V_W+2)'(root_prev) << (K + 1)) + ((V_W+2)'(1) << (2 * K));

      always_ff @(posedge clock) begin
         if (en) begin
            if ((V_W+2)'(rem_prev) >= test) begin
               rem_ff[j]  <= V_W'((V_W+2)'(rem_prev) - test);
               root_ff[j] <= root_prev | (ROOT_W'(1) << K);
            end else begin
               rem_ff[j]  <= rem_prev;
               root_ff[j] <= root_prev;
            end
         end
      end
   end

   assign root_out = root_ff[SQRT_STAGES-1];

endmodule

// ----- src/q2e_cordic.sv -----
module q2e_cordic #(
   parameter int STAGES = 16,
   parameter int LIMIT  = 18000
) (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic signed [q2e_pkg::VEC_W-1:0]     y_in,
   input  logic signed [q2e_pkg::VEC_W-1:0]     x_in,
   output logic signed [q2e_pkg::ANGLE_W-1:0]   angle_out
);
   import q2e_pkg::*;

   logic signed [VEC_W-1:0]   x_pre_ff, y_pre_ff;
   logic signed [ACC_W-1:0]   z_pre_ff;
   logic                      zero_ff [STAGES+1];
   logic signed [VEC_W-1:0]   x_ff [STAGES];
   logic signed [VEC_W-1:0]   y_ff [STAGES];
   logic signed [ACC_W-1:0]   z_ff [STAGES];
   logic signed [ANGLE_W-1:0] angle_ff;

   logic signed [ACC_W-1:0]   rnd;
   logic signed [ACC_W-1:0]   whole;
   logic signed [ANGLE_W-1:0] angle_in;

   // Vectors in the left half plane are turned by a quarter turn first.
   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff[0] <= (x_in == '0) && (y_in == '0);
         if (x_in[VEC_W-1] && !y_in[VEC_W-1]) begin
            x_pre_ff <= y_in;
            y_pre_ff <= -x_in;
            z_pre_ff <= QUARTER_TURN;
         end else if (x_in[VEC_W-1]) begin
            x_pre_ff <= -y_in;
            y_pre_ff <= x_in;
            z_pre_ff <= -QUARTER_TURN;
         end else begin
            x_pre_ff <= x_in;
            y_pre_ff <= y_in;
            z_pre_ff <= '0;
         end
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      localparam logic signed [ACC_W-1:0] STEP = ACC_W'(ATAN_TABLE[i]);
      logic signed [VEC_W-1:0] x_prev, y_prev;
      logic signed [ACC_W-1:0] z_prev;

      if (i == 0) begin : g_first
         assign x_prev = x_pre_ff;
         assign y_prev = y_pre_ff;
         assign z_prev = z_pre_ff;
      end else begin : g_next
         assign x_prev = x_ff[i-1];
         assign y_prev = y_ff[i-1];
         assign z_prev = z_ff[i-1];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            zero_ff[i+1] <= zero_ff[i];
            if (!y_prev[VEC_W-1]) begin
               x_ff[i] <= x_prev + (y_prev >>> i);
               y_ff[i] <= y_prev - (x_prev >>> i);
               z_ff[i] <= z_prev + STEP;
            end else begin
               x_ff[i] <= x_prev - (y_prev >>> i);
               y_ff[i] <= y_prev + (x_prev >>> i);
               z_ff[i] <= z_prev - STEP;
            end
         end
      end
   end

   always_comb begin
      rnd   = z_ff[STAGES-1] + (ACC_W'(1) <<< (ANGLE_FRAC - 1));
      whole = rnd >>> ANGLE_FRAC;
      if (zero_ff[STAGES]) begin
         angle_in = '0;
      end else if (whole > ACC_W'(LIMIT)) begin
         angle_in = ANGLE_W'(LIMIT);
      end else if (whole < -ACC_W'(LIMIT)) begin
         angle_in = -ANGLE_W'(LIMIT);
      end else begin
         angle_in = ANGLE_W'(whole);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         angle_ff <= angle_in;
      end
   end

   assign angle_out = angle_ff;

endmodule

// ----- src/quaternion_to_euler_angles_core.sv -----
// Converts one rotation quaternion per beat into ZYX Euler angles (roll, pitch, yaw) in
// hundredths of a degree, with a flag on tuser that is set when the pitch sine fell outside
// -1..1 and was clamped. A new quaternion can be taken on every clock cycle while the output
// is not stalled; each result passes through one product stage, one sum stage, one squaring
// stage and the 29-stage bit-per-stage square root on the pitch path, and CORDIC_STAGES + 2
// stages in each CORDIC pipeline.
// The whole pipeline holds while a result waits for rsp_tready, so nothing is lost or repeated.
module quaternion_to_euler_angles_core #(
   parameter int COMPONENT_WIDTH = 16,
   parameter int CORDIC_STAGES   = 16
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_tvalid,
   output logic                                          req_tready,
   // quat_x, quat_y, quat_z, quat_w, zero fill
   input  logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0]        req_tdata,
   output logic                                          rsp_tvalid,
   input  logic                                          rsp_tready,
   // roll_angle, pitch_angle, yaw_angle, zero fill
   output logic [q2e_pkg::RSP_DATA_W-1:0]                rsp_tdata,
   // pitch_clamped
   output logic                                          rsp_tuser
);
   import q2e_pkg::*;

   localparam int W          = COMPONENT_WIDTH;
   localparam int FRAC2      = 2 * (W - 2);
   localparam int SHR        = (FRAC2 > QBITS) ? FRAC2 - QBITS : 0;
   localparam int SHL        = (FRAC2 < QBITS) ? QBITS - FRAC2 : 0;
   localparam int SQRT_LAT   = SQRT_STAGES + 1;
   localparam int CORDIC_LAT = CORDIC_STAGES + 2;
   localparam int LAT        = 2 + SQRT_LAT + CORDIC_LAT;
   localparam logic signed [SUM_W-1:0] ONE = SUM_W'(1) <<< QBITS;
   localparam logic [2*QBITS+1:0] SQ_ONE = (2*QBITS+2)'(1) << (2 * QBITS);

   function automatic logic signed [PROD_W-1:0] qmul(logic signed [W-1:0] a,
                                                     logic signed [W-1:0] b);
      logic signed [2*W-1:0] raw;
      logic signed [63:0]    p;
      raw = a * b;
      p   = 64'(raw);
      p   = (p >>> SHR) <<< SHL;
      return PROD_W'(p);
   endfunction

   logic en;
   logic vld_ff [LAT];

   logic signed [W-1:0] qx, qy, qz, qw;
   logic signed [PROD_W-1:0] p_wx_ff, p_yz_ff, p_xx_ff, p_yy_ff, p_wz_ff;
   logic signed [PROD_W-1:0] p_xy_ff, p_zz_ff, p_wy_ff, p_zx_ff;

   logic signed [SUM_W-1:0] rn_in, rd_in, yn_in, yd_in, t_raw;
   logic signed [SUM_W-1:0] rn_ff, rd_ff, yn_ff, yd_ff;
   logic signed [T_W-1:0]   t_in, t_ff;
   logic [AT_W-1:0]         at_in, at_ff;
   logic                    clamp_in, clamp_ff;

   logic [2*QBITS+1:0]      sq;
   logic [V_W-1:0]          v_ff;
   logic [ROOT_W-1:0]       root;

   logic signed [T_W-1:0]     t_dly_ff     [SQRT_LAT];
   logic                      clamp_dly_ff [SQRT_LAT+CORDIC_LAT];
   logic signed [ANGLE_W-1:0] roll_dly_ff  [SQRT_LAT];
   logic signed [ANGLE_W-1:0] yaw_dly_ff   [SQRT_LAT];
   logic signed [ANGLE_W-1:0] roll_ang, yaw_ang, pitch_ang;

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   assign qx = req_tdata[W-1:0];
   assign qy = req_tdata[2*W-1:W];
   assign qz = req_tdata[3*W-1:2*W];
   assign qw = req_tdata[4*W-1:3*W];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAT; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= req_tvalid;
         for (int k = 1; k < LAT; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_wx_ff <= qmul(qw, qx);
         p_yz_ff <= qmul(qy, qz);
         p_xx_ff <= qmul(qx, qx);
         p_yy_ff <= qmul(qy, qy);
         p_wz_ff <= qmul(qw, qz);
         p_xy_ff <= qmul(qx, qy);
         p_zz_ff <= qmul(qz, qz);
         p_wy_ff <= qmul(qw, qy);
         p_zx_ff <= qmul(qz, qx);
      end
   end

   always_comb begin
      rn_in = (SUM_W'(p_wx_ff) + SUM_W'(p_yz_ff)) <<< 1;
      rd_in = ONE - ((SUM_W'(p_xx_ff) + SUM_W'(p_yy_ff)) <<< 1);
      yn_in = (SUM_W'(p_wz_ff) + SUM_W'(p_xy_ff)) <<< 1;
      yd_in = ONE - ((SUM_W'(p_yy_ff) + SUM_W'(p_zz_ff)) <<< 1);
      t_raw = (SUM_W'(p_wy_ff) - SUM_W'(p_zx_ff)) <<< 1;
      if (t_raw > ONE) begin
         t_in     = T_W'(ONE);
         clamp_in = 1'b1;
      end else if (t_raw < -ONE) begin
         t_in     = T_W'(-ONE);
         clamp_in = 1'b1;
      end else begin
         t_in     = T_W'(t_raw);
         clamp_in = 1'b0;
      end
      at_in = t_in[T_W-1] ? AT_W'(-t_in) : AT_W'(t_in);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rn_ff    <= rn_in;
         rd_ff    <= rd_in;
         yn_ff    <= yn_in;
         yd_ff    <= yd_in;
         t_ff     <= t_in;
         at_ff    <= at_in;
         clamp_ff <= clamp_in;
      end
   end

   assign sq = (2*QBITS+2)'(at_ff) * (2*QBITS+2)'(at_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff <= V_W'(SQ_ONE - sq);
      end
   end

   q2e_sqrt u_sqrt (
      .clock    (clock),
      .en       (en),
      .v_in     (v_ff),
      .root_out (root)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         t_dly_ff[0]     <= t_ff;
         clamp_dly_ff[0] <= clamp_ff;
         roll_dly_ff[0]  <= roll_ang;
         yaw_dly_ff[0]   <= yaw_ang;
         for (int k = 1; k < SQRT_LAT; k++) begin
            t_dly_ff[k]    <= t_dly_ff[k-1];
            roll_dly_ff[k] <= roll_dly_ff[k-1];
            yaw_dly_ff[k]  <= yaw_dly_ff[k-1];
         end
         for (int k = 1; k < SQRT_LAT + CORDIC_LAT; k++) begin
            clamp_dly_ff[k] <= clamp_dly_ff[k-1];
         end
      end
   end

   q2e_cordic #(.STAGES(CORDIC_STAGES), .LIMIT(ROLL_LIMIT)) u_roll (
      .clock     (clock),
      .en        (en),
      .y_in      (VEC_W'(rn_ff)),
      .x_in      (VEC_W'(rd_ff)),
      .angle_out (roll_ang)
   );

   q2e_cordic #(.STAGES(CORDIC_STAGES), .LIMIT(ROLL_LIMIT)) u_yaw (
      .clock     (clock),
      .en        (en),
      .y_in      (VEC_W'(yn_ff)),
      .x_in      (VEC_W'(yd_ff)),
      .angle_out (yaw_ang)
   );

   q2e_cordic #(.STAGES(CORDIC_STAGES), .LIMIT(PITCH_LIMIT)) u_pitch (
      .clock     (clock),
      .en        (en),
      .y_in      (VEC_W'(t_dly_ff[SQRT_LAT-1])),
      .x_in      (signed'(VEC_W'(root))),
      .angle_out (pitch_ang)
   );

   assign rsp_tvalid = vld_ff[LAT-1];
   assign rsp_tdata  = RSP_DATA_W'({yaw_dly_ff[SQRT_LAT-1], pitch_ang[PITCH_W-1:0],
                                    roll_dly_ff[SQRT_LAT-1]});
   assign rsp_tuser  = clamp_dly_ff[SQRT_LAT+CORDIC_LAT-1];

endmodule

// ----- src/q2e_checker.sv -----
module q2e_checker #(
   parameter int COMPONENT_WIDTH = 16
) (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_tvalid,
   input logic                                   req_tready,
   input logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0] req_tdata,
   input logic                                   rsp_tvalid,
   input logic                                   rsp_tready,
   input logic [q2e_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   input logic                                   rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid || rsp_tready |-> req_tready)
      else $error("input not ready while output side is free");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[30:16]) <= 15'sd9000)
                  && ($signed(rsp_tdata[30:16]) >= -15'sd9000))
      else $error("pitch out of range");

   a_clamp_pitch: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> ($signed(rsp_tdata[30:16]) == 15'sd9000)
                               || ($signed(rsp_tdata[30:16]) == -15'sd9000))
      else $error("clamped sine without full pitch");

   a_roll_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[15:0]) <= 16'sd18000)
                  && ($signed(rsp_tdata[15:0]) >= -16'sd18000))
      else $error("roll out of range");

endmodule

bind quaternion_to_euler_angles_core q2e_checker #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_q2e_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ----- tb/tb_quaternion_to_euler_angles_core.sv -----
module tb_quaternion_to_euler_angles_core;
   import q2e_pkg::*;

   localparam int CW = 16;
   localparam int STAGES = 16;
   localparam int REQ_W = ((4 * CW + 7) / 8) * 8;
   localparam int LATENCY = STAGES + 34;
   localparam int CYCLE_LIMIT = 400000;
   localparam longint ONE_Q = 64'sd1 <<< QBITS;

   typedef struct packed {
      logic signed [15:0] roll;
      logic signed [14:0] pitch;
      logic signed [15:0] yaw;
      logic               clamped;
   } angles_type;

   localparam longint ATAN_STEP [32] = '{
      294912000, 174096719, 91987925, 46694507, 23437865, 11730358, 5866610, 2933484,
      1466764, 733385, 366693, 183346, 91673, 45837, 22918, 11459, 5730, 2865, 1432,
      716, 358, 179, 90, 45, 22, 11, 6, 3, 1, 1, 0, 0};

   class angle_scoreboard;
      angles_type pending[$];
      int errors;

      function longint fshift(longint v, int s);
         return v >>> s;
      endfunction

      function longint prod(longint a, longint b);
         return fshift(a * b, 2 * (CW - 2) - QBITS);
      endfunction

      function longint isqrt(longint v);
         longint r;
         longint lo;
         longint hi;
         longint m;
         lo = 0;
         hi = 64'd1 << 29;
         while (lo < hi) begin
            m = (lo + hi + 1) / 2;
            if (m * m <= v) lo = m;
            else hi = m - 1;
         end
         r = lo;
         return r;
      endfunction

      function longint vector_angle(longint y, longint x);
         longint z;
         longint t;
         longint nx;
         longint ny;
         z = 0;
         if (x == 0 && y == 0) return 0;
         if (x < 0) begin
            t = x;
            if (y >= 0) begin
               x = y; y = -t; z = QUARTER_TURN;
            end else begin
               x = -y; y = t; z = -QUARTER_TURN;
            end
         end
         for (int i = 0; i < STAGES && i < 32; i++) begin
            if (y >= 0) begin
               nx = x + fshift(y, i); ny = y - fshift(x, i); z += ATAN_STEP[i];
            end else begin
               nx = x - fshift(y, i); ny = y + fshift(x, i); z -= ATAN_STEP[i];
            end
            x = nx;
            y = ny;
         end
         return z;
      endfunction

      function longint centideg(longint acc, longint limit);
         longint a;
         a = fshift(acc + (64'sd1 <<< (ANGLE_FRAC - 1)), ANGLE_FRAC);
         if (a > limit) a = limit;
         if (a < -limit) a = -limit;
         return a;
      endfunction

      function void note_quaternion(logic [REQ_W-1:0] d);
         longint qx, qy, qz, qw, rn, rd, yn, yd, t, at;
         angles_type e;
         qx = longint'($signed(d[15:0]));
         qy = longint'($signed(d[31:16]));
         qz = longint'($signed(d[47:32]));
         qw = longint'($signed(d[63:48]));
         rn = 2 * (prod(qw, qx) + prod(qy, qz));
         rd = ONE_Q - 2 * (prod(qx, qx) + prod(qy, qy));
         yn = 2 * (prod(qw, qz) + prod(qx, qy));
         yd = ONE_Q - 2 * (prod(qy, qy) + prod(qz, qz));
         t = 2 * (prod(qw, qy) - prod(qz, qx));
         e.clamped = 1'b0;
         if (t > ONE_Q) begin
            t = ONE_Q; e.clamped = 1'b1;
         end
         if (t < -ONE_Q) begin
            t = -ONE_Q; e.clamped = 1'b1;
         end
         at = t < 0 ? -t : t;
         e.roll = 16'(centideg(vector_angle(rn, rd), ROLL_LIMIT));
         e.pitch = 15'(centideg(vector_angle(t, isqrt((64'sd1 <<< 56) - at * at)),
                                PITCH_LIMIT));
         e.yaw = 16'(centideg(vector_angle(yn, yd), ROLL_LIMIT));
         pending = {pending, e};
      endfunction

      function void check_angles(logic [RSP_DATA_W-1:0] d, logic flag);
         angles_type e;
         angles_type a;
         a.roll = d[15:0];
         a.pitch = d[30:16];
         a.yaw = d[46:31];
         a.clamped = flag;
         if (pending.size() == 0) begin
            $display("%0t unexpected beat: expected none, actual %h %b", $time, d, flag);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.roll !== e.roll) begin
            $display("%0t roll: expected %0d, actual %0d", $time, e.roll, a.roll);
            errors++;
         end
         if (a.pitch !== e.pitch) begin
            $display("%0t pitch: expected %0d, actual %0d", $time, e.pitch, a.pitch);
            errors++;
         end
         if (a.yaw !== e.yaw) begin
            $display("%0t yaw: expected %0d, actual %0d", $time, e.yaw, a.yaw);
            errors++;
         end
         if (a.clamped !== e.clamped) begin
            $display("%0t clamp flag: expected %b, actual %b", $time, e.clamped, a.clamped);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tuser;

   angle_scoreboard board;
   int cycles = 0;
   bit hold_off;

   quaternion_to_euler_angles_core #(.COMPONENT_WIDTH(CW), .CORDIC_STAGES(STAGES)) DUT (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser));

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL quaternion_to_euler_angles_core");
         $finish;
      end
      if (!reset && req_tvalid && req_tready) board.note_quaternion(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) board.check_angles(rsp_tdata, rsp_tuser);
   end

   initial begin
      int mode;
      rsp_tready = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_tready <= 0;
            repeat (300) @(negedge clock);
            hold_off = 0;
         end
         mode = $urandom_range(0, 3);
         repeat ($urandom_range(5, 60)) begin
            case (mode)
               0: rsp_tready <= 1;
               1: rsp_tready <= $urandom_range(0, 3) != 0;
               2: rsp_tready <= 1'($urandom_range(0, 1));
               default: rsp_tready <= $urandom_range(0, 4) == 0;
            endcase
            @(negedge clock);
         end
      end
   end

   task automatic send_quaternion(logic [15:0] qx, logic [15:0] qy, logic [15:0] qz,
                                  logic [15:0] qw);
      req_tvalid <= 1;
      req_tdata <= {qw, qz, qy, qx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic idle_sender(int n);
      req_tvalid <= 0;
      repeat (n) @(negedge clock);
   endtask

   function automatic logic [15:0] rand_component(int kind);
      case (kind)
         0: return 16'($urandom());
         1: return 16'($signed($urandom_range(0, 32768)) - 16384);
         2: return 16'($signed($urandom_range(0, 2000)) - 1000);
         default: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      endcase
   endfunction

   task automatic send_unit_like();
      real a, b, c, d, n;
      a = $signed($urandom_range(0, 2000)) - 1000.0;
      b = $signed($urandom_range(0, 2000)) - 1000.0;
      c = $signed($urandom_range(0, 2000)) - 1000.0;
      d = $signed($urandom_range(0, 2000)) - 1000.0;
      n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
      send_quaternion(16'($rtoi(a / n * 16384.0)), 16'($rtoi(b / n * 16384.0)),
                      16'($rtoi(c / n * 16384.0)), 16'($rtoi(d / n * 16384.0)));
   endtask

   initial begin
      int kind;
      board = new();
      hold_off = 0;
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;

      send_quaternion(16'sd0, 16'sd0, 16'sd0, 16'sd16384);
      send_quaternion(16'sd0, 16'sd0, 16'sd0, 16'sd0);
      send_quaternion(16'sd16384, 16'sd0, 16'sd0, 16'sd0);
      send_quaternion(16'sd0, 16'sd16384, 16'sd0, 16'sd0);
      send_quaternion(16'sd0, 16'sd0, 16'sd16384, 16'sd0);
      send_quaternion(16'sd0, 16'sd11585, 16'sd0, 16'sd11585);
      send_quaternion(16'sd0, -16'sd11585, 16'sd0, 16'sd11585);
      send_quaternion(16'sd0, 16'sd16384, 16'sd0, 16'sd16384);
      send_quaternion(16'sd0, -16'sd16384, 16'sd0, 16'sd16384);
      send_quaternion(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
      send_quaternion(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_quaternion(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
      send_quaternion(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
      send_quaternion(16'hffff, 16'hffff, 16'hffff, 16'hffff);
      send_quaternion(16'sd11585, 16'sd0, 16'sd0, -16'sd11585);
      send_quaternion(16'sd0, 16'sd0, 16'sd11585, -16'sd11585);
      send_quaternion(16'sd1, 16'sd0, 16'sd0, 16'sd0);
      send_quaternion(16'sd0, 16'sd0, 16'sd0, -16'sd16384);
      send_quaternion(16'sd16384, 16'sd16384, 16'sd0, 16'sd0);
      send_quaternion(16'sd0, 16'sd0, 16'sd16384, 16'sd16384);

      hold_off = 1;
      repeat (120) send_unit_like();
      while (board.pending.size() != 0) idle_sender(1);

      for (int n = 0; n < 900;) begin
         repeat ($urandom_range(1, 40)) begin
            if (n < 900) begin
               kind = $urandom_range(0, 9);
               if (kind < 6) send_unit_like();
               else send_quaternion(rand_component(kind - 6), rand_component(kind - 6),
                                    rand_component($urandom_range(0, 3)),
                                    rand_component(kind - 6));
               n++;
            end
         end
         if ($urandom_range(0, 2) == 0) idle_sender($urandom_range(1, 20));
      end
      req_tvalid <= 0;

      while (board.pending.size() != 0) @(negedge clock);
      repeat (LATENCY + 20) @(negedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("PASS quaternion_to_euler_angles_core");
      end else begin
         $display("FAIL quaternion_to_euler_angles_core");
      end
      $finish;
   end

endmodule
